// ----- hw/rtl/srp_pkg.sv -----
// srp_pkg: shared widths and reset constants for the serial-to-radio packetizer.
// No dependencies.
package srp_pkg;

   localparam int BYTE_W = 8;
   localparam int IDX_W  = 5;
   localparam int ADDR_W = 24;

   localparam logic [ADDR_W-1:0] DEST_RESET = 24'h0F0101;

   // reciprocal scale for the count-mod-packet split
   localparam int RECIP_SHIFT = 16;

endpackage

// ----- hw/rtl/serial_to_radio_packetizer.sv -----
// serial_to_radio_packetizer: collects serial bytes into header and code packets in a
// one-port payload RAM and streams each finished packet out beat by beat.
// Depends on srp_pkg.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_serial_byte
//   rsp     | out       | rsp_valid/rsp_stall  | packet, index, flags, destination
//   csr     | in        | csr_wr_en            | csr_wr_data (destination address)
//
// A byte that completes no packet leaves req unstalled. A byte that completes a packet starts
// a readout of PACKET_BYTES beats from the payload RAM, one RAM read per cycle, and req is
// stalled until every beat is issued. A rsp stall holds the readout in place. Reset clears the
// phase, count, beat counter and valid flags and loads DEST_RESET; the RAM needs no clearing pass.
module serial_to_radio_packetizer
   import srp_pkg::*;
#(
   parameter int PACKET_BYTES   = 28,
   parameter int COUNT_POSITION = 3
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_serial_byte,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_packet_byte,
   output logic [IDX_W-1:0]  rsp_byte_index,
   output logic              rsp_is_header,
   output logic              rsp_last,
   output logic [ADDR_W-1:0] rsp_destination,
   output logic              rsp_enter_receive,

   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data
);

   localparam int PW    = $clog2(PACKET_BYTES + 1);
   localparam int IW    = $clog2(PACKET_BYTES);
   localparam int PRODW = BYTE_W + RECIP_SHIFT;
   localparam int MULT  = ((1 << RECIP_SHIFT) + PACKET_BYTES - 1) / PACKET_BYTES;

   logic [BYTE_W-1:0] payload_mem [PACKET_BYTES];

   logic [ADDR_W-1:0] dest_ff, dest_in;
   logic [PW-1:0]     hp_ff, hp_in;
   logic [BYTE_W-1:0] cnt_ff, cnt_in;
   logic [IW-1:0]     rmod_ff, rmod_in;
   logic [BYTE_W-1:0] q_ff, q_in;
   logic              load_ff, load_in;
   logic [PW-1:0]     emit_left_ff, emit_left_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic              emit_hdr_ff, emit_hdr_in;
   logic              pend_ff, pend_in;
   logic [IW-1:0]     pend_idx_ff;
   logic              pend_hdr_ff;
   logic [BYTE_W-1:0] mem_q_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic [IW-1:0]     rsp_idx_ff;
   logic              rsp_hdr_ff;
   logic              rsp_last_ff;
   logic [ADDR_W-1:0] rsp_dest_ff;

   logic              accept, hdr_phase, latch, hdr_done;
   logic [BYTE_W-1:0] count_eff;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic              move, issue;
   logic [PRODW-1:0]  prod;
   logic [BYTE_W-1:0] qp;
   logic [BYTE_W-1:0] rem_full;

   assign req_stall = (emit_left_ff != '0);
   assign accept    = req_valid && !req_stall;
   assign hdr_phase = (hp_ff != PW'(PACKET_BYTES));
   assign latch     = hdr_phase && (hp_ff == PW'(COUNT_POSITION));
   assign hdr_done  = (hp_ff == PW'(PACKET_BYTES - 1));
   assign count_eff = latch ? req_serial_byte : cnt_ff;

   assign prod     = PRODW'(req_serial_byte) * PRODW'(MULT);
   assign qp       = q_ff * BYTE_W'(PACKET_BYTES);
   assign rem_full = cnt_ff - qp;

   assign move  = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue = (emit_left_ff != '0) && (!pend_ff || move);

   always_comb begin
      dest_in      = csr_wr_en ? csr_wr_data : dest_ff;
      hp_in        = hp_ff;
      cnt_in       = cnt_ff;
      rmod_in      = rmod_ff;
      q_in         = q_ff;
      load_in      = 1'b0;
      emit_left_in = emit_left_ff;
      rd_idx_in    = rd_idx_ff;
      emit_hdr_in  = emit_hdr_ff;
      wr_en        = 1'b0;
      wr_addr      = hp_ff[IW-1:0];

      if (load_ff) begin
         rmod_in = rem_full[IW-1:0];
      end

      if (issue) begin
         emit_left_in = emit_left_ff - PW'(1);
         rd_idx_in    = rd_idx_ff + IW'(1);
      end

      if (accept) begin
         wr_en = 1'b1;
         if (hdr_phase) begin
            if (latch) begin
               cnt_in  = req_serial_byte;
               q_in    = prod[PRODW-1:RECIP_SHIFT];
               load_in = 1'b1;
            end
            if (hdr_done) begin
               hp_in        = (count_eff == '0) ? '0 : PW'(PACKET_BYTES);
               emit_left_in = PW'(PACKET_BYTES);
               rd_idx_in    = '0;
               emit_hdr_in  = 1'b1;
            end else begin
               hp_in = hp_ff + PW'(1);
            end
         end else begin
            cnt_in = cnt_ff - BYTE_W'(1);
            if (rmod_ff == '0) begin
               wr_addr = '0;
               rmod_in = IW'(PACKET_BYTES - 1);
            end else begin
               wr_addr = IW'(PACKET_BYTES) - rmod_ff;
               rmod_in = rmod_ff - IW'(1);
            end
            if (cnt_in == '0) begin
               hp_in = '0;
            end
            if (rmod_ff == IW'(1)) begin
               emit_left_in = PW'(PACKET_BYTES);
               rd_idx_in    = '0;
               emit_hdr_in  = 1'b0;
            end
         end
      end

      if (issue) begin
         pend_in = 1'b1;
      end else if (move) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end

      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_ff      <= DEST_RESET;
         hp_ff        <= '0;
         cnt_ff       <= '0;
         load_ff      <= 1'b0;
         emit_left_ff <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dest_ff      <= dest_in;
         hp_ff        <= hp_in;
         cnt_ff       <= cnt_in;
         load_ff      <= load_in;
         emit_left_ff <= emit_left_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rmod_ff     <= rmod_in;
      q_ff        <= q_in;
      rd_idx_ff   <= rd_idx_in;
      emit_hdr_ff <= emit_hdr_in;
      if (issue) begin
         pend_idx_ff <= rd_idx_ff;
         pend_hdr_ff <= emit_hdr_ff;
      end
      if (move) begin
         rsp_byte_ff <= mem_q_ff;
         rsp_idx_ff  <= pend_idx_ff;
         rsp_hdr_ff  <= pend_hdr_ff;
         rsp_last_ff <= (pend_idx_ff == IW'(PACKET_BYTES - 1));
         rsp_dest_ff <= dest_ff;
      end
   end

   // reads and writes never share a cycle: req is stalled while beats are issued
   always_ff @(posedge clock) begin
      if (wr_en) begin
         payload_mem[wr_addr] <= req_serial_byte;
      end
      if (issue) begin
         mem_q_ff <= payload_mem[rd_idx_ff];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_packet_byte   = rsp_byte_ff;
   assign rsp_byte_index    = IDX_W'(rsp_idx_ff);
   assign rsp_is_header     = rsp_hdr_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_destination   = rsp_dest_ff;
   assign rsp_enter_receive = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_byte_index == IDX_W'(PACKET_BYTES - 1))
      else $error("last beat at wrong index");

   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !move |=> pend_ff && $stable(mem_q_ff) && $stable(pend_idx_ff))
      else $error("pending RAM beat lost");

   a_code_count: assert property (@(posedge clock) disable iff (reset)
      hp_ff == PW'(PACKET_BYTES) |-> cnt_ff != '0)
      else $error("code phase with zero count");

   a_rmod_range: assert property (@(posedge clock) disable iff (reset)
      hp_ff == PW'(PACKET_BYTES) && !load_ff |-> rmod_ff < IW'(PACKET_BYTES))
      else $error("slot remainder out of range");
`endif

endmodule

// ----- sim/serial_to_radio_packetizer_tb.sv -----
// serial_to_radio_packetizer_tb: self-checking bench for the packetizer, with header and
// code frames, random stalls and destination writes, scored against a behavioral predictor.
// Depends on srp_pkg and serial_to_radio_packetizer.
module serial_to_radio_packetizer_tb
   import srp_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PKT     = 28;
   localparam int CNT_POS = 3;
   localparam int RAND_BYTES = 60;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [IDX_W-1:0]  idx;
      logic              hdr;
      logic              last;
      logic [ADDR_W-1:0] dest;
      logic              rx;
   } pkt_beat_type;

   typedef struct packed {
      logic              wr;
      logic [ADDR_W-1:0] wdata;
      logic [BYTE_W-1:0] count;
      logic [BYTE_W-1:0] fill;
      logic              typed;
      logic [ADDR_W-1:0] tdest;
   } frame_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [BYTE_W-1:0] req_serial_byte;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [BYTE_W-1:0] rsp_packet_byte;
   logic [IDX_W-1:0]  rsp_byte_index;
   logic              rsp_is_header;
   logic              rsp_last;
   logic [ADDR_W-1:0] rsp_destination;
   logic              rsp_enter_receive;
   logic              csr_wr_en;
   logic [ADDR_W-1:0] csr_wr_data;

   // predictor state
   int                hdr_pos;
   logic [BYTE_W-1:0] code_left;
   logic [BYTE_W-1:0] slots [PKT];
   logic [ADDR_W-1:0] dest_now;
   bit                hand_typed;

   pkt_beat_type beats_due[$];
   int           errors;
   bit           calm;
   bit           hold_go;

   serial_to_radio_packetizer #(
      .PACKET_BYTES(PKT),
      .COUNT_POSITION(CNT_POS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_serial_byte(req_serial_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_packet_byte(rsp_packet_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_is_header(rsp_is_header),
      .rsp_last(rsp_last),
      .rsp_destination(rsp_destination),
      .rsp_enter_receive(rsp_enter_receive),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      errors++;
      $display("%0t ERROR: %s", $time, msg);
   endtask

   task automatic queue_packet(input logic is_hdr);
      pkt_beat_type b;
      if (hand_typed) begin
         return;
      end
      for (int k = 0; k < PKT; k++) begin
         b.data = slots[k];
         b.idx  = IDX_W'(k);
         b.hdr  = is_hdr;
         b.last = (k == PKT - 1);
         b.dest = dest_now;
         b.rx   = (k == PKT - 1);
         beats_due.push_back(b);
      end
   endtask

   task automatic absorb_byte(input logic [BYTE_W-1:0] b);
      int r;
      if (hdr_pos < PKT) begin
         slots[hdr_pos] = b;
         if (hdr_pos == CNT_POS) begin
            code_left = b;
         end
         hdr_pos++;
         if (hdr_pos == PKT) begin
            if (code_left == 0) begin
               hdr_pos = 0;
            end
            queue_packet(1'b1);
         end
      end else begin
         r = int'(code_left) % PKT;
         slots[(r == 0) ? 0 : PKT - r] = b;
         code_left = code_left - 8'd1;
         if (r != 0) begin
            if (code_left == 0) begin
               hdr_pos = 0;
            end
            if (int'(code_left) % PKT == 0) begin
               queue_packet(1'b0);
            end
         end
      end
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_serial_byte <= b;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      absorb_byte(b);
   endtask

   task automatic run_frame(input logic [BYTE_W-1:0] cnt, input logic [BYTE_W-1:0] fill,
                            input bit rnd);
      logic [BYTE_W-1:0] b;
      for (int k = 0; k < PKT; k++) begin
         b = (k == CNT_POS) ? cnt : (rnd ? BYTE_W'($urandom) : fill);
         send_byte(b);
      end
      for (int i = 0; i < int'(cnt); i++) begin
         send_byte(BYTE_W'($urandom));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (PKT + 4) @(posedge clock);
   endtask

   task automatic write_dest(input logic [ADDR_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      dest_now = v;
   endtask

   task automatic check_beat();
      pkt_beat_type want;
      if (beats_due.size() == 0) begin
         flag_mismatch($sformatf("unexpected beat byte=%h idx=%0d",
                                 rsp_packet_byte, rsp_byte_index));
         return;
      end
      want = beats_due.pop_front();
      if (rsp_packet_byte !== want.data)
         flag_mismatch($sformatf("idx %0d byte %h, want %h", want.idx, rsp_packet_byte,
                                 want.data));
      if (rsp_byte_index !== want.idx)
         flag_mismatch($sformatf("byte_index %0d, want %0d", rsp_byte_index, want.idx));
      if (rsp_is_header !== want.hdr)
         flag_mismatch($sformatf("idx %0d is_header %b, want %b", want.idx, rsp_is_header,
                                 want.hdr));
      if (rsp_last !== want.last)
         flag_mismatch($sformatf("idx %0d last %b, want %b", want.idx, rsp_last, want.last));
      if (rsp_destination !== want.dest)
         flag_mismatch($sformatf("idx %0d destination %h, want %h", want.idx,
                                 rsp_destination, want.dest));
      if (rsp_enter_receive !== want.rx)
         flag_mismatch($sformatf("idx %0d enter_receive %b, want %b", want.idx,
                                 rsp_enter_receive, want.rx));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_beat();
      end
   end

   // receiver: random stalls, a quiet stretch, and one long hold-off on request
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 21);
         end
      end
   end

   initial begin : stim
      frame_row_type     plan [5];
      pkt_beat_type      b;
      int                rand_sent;
      int                frame_no;
      int                sel;
      int                pick;
      logic [BYTE_W-1:0] cnt;

      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_serial_byte <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      errors     = 0;
      calm       = 1'b0;
      hold_go    = 1'b0;
      hand_typed = 1'b0;
      hdr_pos    = 0;
      code_left  = '0;
      dest_now   = DEST_RESET;
      for (int k = 0; k < PKT; k++) begin
         slots[k] = '0;
      end

      // wr, wdata, count, fill, typed, expected destination
      plan[0] = '{1'b0, 24'h000000, 8'd0,   8'h00, 1'b1, DEST_RESET};
      plan[1] = '{1'b1, 24'hFFFFFF, 8'd0,   8'hFF, 1'b1, 24'hFFFFFF};
      plan[2] = '{1'b1, 24'h000000, 8'd0,   8'h80, 1'b1, 24'h000000};
      plan[3] = '{1'b0, 24'h000000, 8'd1,   8'h01, 1'b0, 24'h000000};
      plan[4] = '{1'b1, 24'hA5C3E1, 8'd255, 8'hAA, 1'b0, 24'h000000};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 5; i++) begin
         if (plan[i].wr) begin
            drain();
            write_dest(plan[i].wdata);
         end
         // the longest frame runs with no idling on either side
         calm       = (plan[i].count == 8'd255);
         hand_typed = plan[i].typed;
         run_frame(plan[i].count, plan[i].fill, 1'b0);
         if (plan[i].typed) begin
            // zero count: header packet only, fill bytes with the count slot cleared
            for (int k = 0; k < PKT; k++) begin
               b.data = (k == CNT_POS) ? 8'h00 : plan[i].fill;
               b.idx  = IDX_W'(k);
               b.hdr  = 1'b1;
               b.last = (k == PKT - 1);
               b.dest = plan[i].tdest;
               b.rx   = (k == PKT - 1);
               beats_due.push_back(b);
            end
         end
         hand_typed = 1'b0;
      end
      calm = 1'b0;

      rand_sent = 0;
      frame_no  = 0;
      while (rand_sent < RAND_BYTES) begin
         if (frame_no == 0) begin
            hold_go = 1'b1;
         end
         if ($urandom_range(99) < 25) begin
            drain();
            pick = $urandom_range(3);
            write_dest((pick == 0) ? 24'h000000 :
                       (pick == 1) ? 24'hFFFFFF : ADDR_W'($urandom));
         end
         sel = $urandom_range(99);
         if (sel < 15) begin
            cnt = 8'd0;
         end else if (sel < 60) begin
            cnt = BYTE_W'($urandom_range(1, 30));
         end else if (sel < 85) begin
            cnt = BYTE_W'($urandom_range(31, 84));
         end else begin
            cnt = BYTE_W'($urandom_range(85, 255));
         end
         run_frame(cnt, 8'h00, 1'b1);
         rand_sent += PKT + int'(cnt);
         frame_no++;
      end
      calm = 1'b0;

      req_valid <= 1'b0;
      @(posedge clock);
      while (beats_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * PKT) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/srp_pkg.sv
hw/rtl/serial_to_radio_packetizer.sv
sim/serial_to_radio_packetizer_tb.sv
